### src/ctq_pkg.sv
// Package for the compacting task queue: sizing constants, command codes
// and the request and result word types. No dependencies.
`timescale 1ns / 1ps

package ctq_pkg;

    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 16;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_SEARCH  = 2'd2,
        CMD_REMOVE  = 2'd3
    } ctq_cmd_t;

    typedef struct packed {
        ctq_cmd_t    command;
        logic [15:0] task_handle;
        logic [3:0]  position;
    } ctq_req_t;

    typedef struct packed {
        logic        success;
        logic [15:0] handle_out;
        logic        found;
        logic [4:0]  occupancy;
        logic        empty_flag;
    } ctq_rsp_t;

endpackage

### src/ctq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ctq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/compacting_task_queue_unit.sv
// Compacting task queue, top level: command sequencer around one entry RAM.
// Depends on ctq_pkg and ctq_ram.
// Sequence: enqueue and failing commands go from accept straight to the done
// state. Dequeue/remove at index i read entry i, then move each later entry
// down one place; search makes one RAM read per entry, stops on first hit.
// One word at a time: busy stays high until the cycle after done. The
// receiver cannot stall. rst_n (async, active low) empties the queue.
`timescale 1ns / 1ps

module compacting_task_queue_unit
    import ctq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ctq_req_t request,
    output logic     busy,
    output logic     done,
    output ctq_rsp_t result
);

    // one-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_TAKE   = 5'b00010,  // read data of the entry being taken out
        S_SHIFT  = 5'b00100,  // move entry ptr+1 down to ptr, one per cycle
        S_SEARCH = 5'b01000,  // compare entry ptr against the key
        S_DONE   = 5'b10000   // result strobe
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [HANDLE_BITS-1:0] key_reg, key_next;
    logic                   success_reg, success_next;
    logic                   found_reg, found_next;
    logic [15:0]            hout_reg, hout_next;

    // RAM port signals
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [HANDLE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [HANDLE_BITS-1:0] ram_rdata;

    logic                   accept;
    logic [CNT_W:0]         ptr_plus1;
    logic [CNT_W:0]         ptr_plus2;
    logic [CNT_W+3:0]       pos_ext;
    logic [CNT_W+3:0]       cnt_ext;

    ctq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (HANDLE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign ptr_plus1 = (CNT_W+1)'(ptr_reg) + (CNT_W+1)'(1);
    assign ptr_plus2 = (CNT_W+1)'(ptr_reg) + (CNT_W+1)'(2);
    assign pos_ext   = (CNT_W+4)'(request.position);
    assign cnt_ext   = (CNT_W+4)'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        key_next     = key_reg;
        success_next = success_reg;
        found_next   = found_reg;
        hout_next    = hout_reg;
        ram_we       = 1'b0;
        ram_waddr    = ptr_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    success_next = 1'b0;
                    found_next   = 1'b0;
                    hout_next    = '0;
                    key_next     = HANDLE_BITS'(request.task_handle);
                    state_next   = S_DONE;
                    case (request.command)
                        CMD_ENQUEUE:
                        begin
                            if (count_reg < CNT_W'(CAPACITY))
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = IDX_W'(count_reg);
                                ram_wdata    = HANDLE_BITS'(request.task_handle);
                                count_next   = count_reg + CNT_W'(1);
                                success_next = 1'b1;
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_TAKE;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            success_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                ram_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            // index at or past the count fails
                            if (pos_ext < cnt_ext)
                            begin
                                ram_raddr  = IDX_W'(request.position);
                                ptr_next   = IDX_W'(request.position);
                                state_next = S_TAKE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_TAKE:
            begin
                hout_next    = 16'(ram_rdata);
                success_next = 1'b1;
                if (ptr_plus1 < (CNT_W+1)'(count_reg))
                begin
                    ram_raddr  = IDX_W'(ptr_plus1);
                    state_next = S_SHIFT;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // rdata holds entry ptr+1; write it one place down
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ptr_next  = IDX_W'(ptr_plus1);
                if (ptr_plus2 < (CNT_W+1)'(count_reg))
                begin
                    ram_raddr = IDX_W'(ptr_plus2);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_SEARCH:
            begin
                if (ram_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (ptr_plus1 < (CNT_W+1)'(count_reg))
                begin
                    ram_raddr = IDX_W'(ptr_plus1);
                    ptr_next  = IDX_W'(ptr_plus1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        key_reg     <= key_next;
        success_reg <= success_next;
        found_reg   <= found_next;
        hout_reg    <= hout_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    // count is final by the time the strobe is up
    always_comb
    begin
        result.success    = success_reg;
        result.handle_out = hout_reg;
        result.found      = found_reg;
        result.occupancy  = 5'(count_reg);
        result.empty_flag = (count_reg == '0);
    end

endmodule

### src/ctq_checker.sv
// Port-level checks for the compacting task queue, bound to the top level.
// Depends on ctq_pkg.
`timescale 1ns / 1ps

module ctq_checker
    import ctq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input ctq_rsp_t result
);

    // an accepted word always sets busy in the cycle after accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("ctq: no busy after accept");

    // strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("ctq: done held");

    // empty flag agrees with occupancy
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.empty_flag == (result.occupancy == 5'd0)))
        else $error("ctq: empty flag mismatch");

    // a hit is only reported by a successful search, with handle_out zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.success && (result.handle_out == 16'd0)))
        else $error("ctq: found without success");

    // occupancy never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.occupancy) <= CAPACITY))
        else $error("ctq: occupancy over capacity");

endmodule

bind compacting_task_queue_unit ctq_checker u_ctq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### sim/compacting_task_queue_unit_test.sv
// Self-checking bench for compacting_task_queue_unit: directed table, then random
// command words; every result word is scored against a pinned row or a queue predictor.
// Depends on ctq_pkg and the unit under test; reads no files.
`timescale 1ns / 1ps

module compacting_task_queue_unit_test;

    import ctq_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_WORDS = 1100;
    localparam int SETTLE_LIMIT = 2000;   // cycles allowed for the last results
    localparam int TAIL_CYCLES  = 40;     // longer than the slowest command
    localparam int REPORT_MAX   = 10;

    // Rows of the directed table. A pinned row carries its own result word;
    // all others are scored against the predictor.
    typedef struct {
        ctq_cmd_t    cmd;
        logic [15:0] handle;
        logic [3:0]  pos;
        int          reps;      // row sent reps times, handle + k for repeat k
        bit          pinned;
        ctq_rsp_t    rsp;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    ctq_req_t request;
    logic     busy;
    logic     done;
    ctq_rsp_t result;

    // Side channel, driven with each request: pinned result for directed rows.
    bit       pin_use;
    ctq_rsp_t pin_rsp;

    // Predictor state: the valid entries, front at index 0.
    logic [HANDLE_BITS-1:0] slot_q[$];

    // Result words still owed by the unit, oldest first.
    ctq_rsp_t  owed_q[$];
    stim_row_t dir_rows[$];

    int mismatches = 0;
    int sent_words = 0;
    int cmd_seen[4];
    int refused    = 0;
    int search_hits = 0;
    int full_hits  = 0;
    int max_fill   = 0;

    compacting_task_queue_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop: several times the slowest legal run (long gaps, full-depth
    // shifts on every word).
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Queue behavior for one accepted word; updates slot_q.
    function automatic ctq_rsp_t apply_command(input ctq_req_t w);
        ctq_rsp_t r;
        r = '0;
        case (w.command)
            CMD_ENQUEUE:
            begin
                if (slot_q.size() < CAPACITY)
                begin
                    slot_q.push_back(w.task_handle);
                    r.success = 1'b1;
                end
            end
            CMD_DEQUEUE:
            begin
                if (slot_q.size() > 0)
                begin
                    r.handle_out = slot_q.pop_front();
                    r.success    = 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                r.success = 1'b1;
                foreach (slot_q[i])
                    if (slot_q[i] == w.task_handle)
                        r.found = 1'b1;
            end
            default:
            begin
                // remove at index; index at or past the count is refused
                if (w.position < slot_q.size())
                begin
                    r.handle_out = slot_q[w.position];
                    slot_q.delete(w.position);
                    r.success = 1'b1;
                end
            end
        endcase
        r.occupancy  = 5'(slot_q.size());
        r.empty_flag = (slot_q.size() == 0);
        return r;
    endfunction

    // Monitor: on accept, predict and queue the expected word; on done, score
    // against the oldest one. Outputs and inputs are sampled at the edge,
    // before any NBA of that step lands.
    always @(posedge clk)
    begin
        ctq_rsp_t want;
        ctq_rsp_t model;
        if (rst_n)
        begin
            if (done)
            begin
                if (owed_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result word with nothing owed: %p", $realtime, result);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (result.success !== want.success ||
                        result.handle_out !== want.handle_out ||
                        result.found !== want.found ||
                        result.occupancy !== want.occupancy ||
                        result.empty_flag !== want.empty_flag)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch: expected ok=%b h=%h f=%b n=%0d e=%b",
                                     $realtime, want.success, want.handle_out, want.found,
                                     want.occupancy, want.empty_flag);
                            $display("    got ok=%b h=%h f=%b n=%0d e=%b",
                                     result.success, result.handle_out, result.found,
                                     result.occupancy, result.empty_flag);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                model = apply_command(request);
                want  = pin_use ? pin_rsp : model;
                owed_q.push_back(want);
                cmd_seen[request.command]++;
                if (!model.success)
                    refused++;
                if (model.found)
                    search_hits++;
                if (request.command == CMD_ENQUEUE && !model.success)
                    full_hits++;
                if (slot_q.size() > max_fill)
                    max_fill = slot_q.size();
            end
        end
    end

    // Idle gap after a word: mostly none or short, now and then long.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Present one word and hold it until accepted. With gap 0, start stays
    // high for the next word (no low/high pair in one step).
    task automatic send_word(input ctq_req_t w, input bit pin, input ctq_rsp_t pr,
                             input int gap);
        request <= w;
        pin_use <= pin;
        pin_rsp <= pr;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_words++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender holds off until every owed result word has arrived or SETTLE_LIMIT runs out.
    task automatic drain_owed();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while (owed_q.size() > 0 && guard < SETTLE_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    task automatic row(input ctq_cmd_t cmd, input logic [15:0] handle, input logic [3:0] pos,
                       input int reps, input bit pinned, input logic ok,
                       input logic [15:0] h, input logic f, input logic [4:0] n,
                       input logic e);
        stim_row_t s;
        s.cmd    = cmd;
        s.handle = handle;
        s.pos    = pos;
        s.reps   = reps;
        s.pinned = pinned;
        s.rsp.success    = ok;
        s.rsp.handle_out = h;
        s.rsp.found      = f;
        s.rsp.occupancy  = n;
        s.rsp.empty_flag = e;
        dir_rows.push_back(s);
    endtask

    initial
    begin
        ctq_req_t    w;
        logic [15:0] pool[8];
        int          mode;
        int          r;
        bit          calm;

        pool = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001,
                 16'h7FFE, 16'hA5A5, 16'h0F0F, 16'hC3C3};

        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        pin_use <= 1'b0;
        pin_rsp <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Pinned rows: empty-queue refusals, both handle
        // extremes, full-queue refusal, remove past the count.
        row(CMD_DEQUEUE, 16'h0000, 4'd0,  1, 1, 0, 16'h0000, 0, 5'd0,  1);
        row(CMD_REMOVE,  16'h0000, 4'd0,  1, 1, 0, 16'h0000, 0, 5'd0,  1);
        row(CMD_REMOVE,  16'hFFFF, 4'd15, 1, 1, 0, 16'h0000, 0, 5'd0,  1);
        row(CMD_SEARCH,  16'h0000, 4'd0,  1, 1, 1, 16'h0000, 0, 5'd0,  1);
        row(CMD_ENQUEUE, 16'h0000, 4'd0,  1, 1, 1, 16'h0000, 0, 5'd1,  0);
        row(CMD_ENQUEUE, 16'hFFFF, 4'd15, 1, 1, 1, 16'h0000, 0, 5'd2,  0);
        row(CMD_SEARCH,  16'hFFFF, 4'd0,  1, 1, 1, 16'h0000, 1, 5'd2,  0);
        row(CMD_SEARCH,  16'h5A5A, 4'd0,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_DEQUEUE, 16'hFFFF, 4'd15, 1, 1, 1, 16'h0000, 0, 5'd1,  0);
        row(CMD_DEQUEUE, 16'h0000, 4'd0,  1, 1, 1, 16'hFFFF, 0, 5'd0,  1);
        row(CMD_ENQUEUE, 16'hA000, 4'd0, 16, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_ENQUEUE, 16'hBEEF, 4'd0,  1, 1, 0, 16'h0000, 0, 5'd16, 0);
        row(CMD_SEARCH,  16'hA00F, 4'd0,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_SEARCH,  16'hFFFF, 4'd0,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_REMOVE,  16'h0000, 4'd15, 1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_REMOVE,  16'h0000, 4'd15, 1, 1, 0, 16'h0000, 0, 5'd15, 0);
        row(CMD_REMOVE,  16'h0000, 4'd0,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_REMOVE,  16'h0000, 4'd7,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_SEARCH,  16'hA000, 4'd0,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_ENQUEUE, 16'h5555, 4'd0,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_SEARCH,  16'h5555, 4'd0,  1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_REMOVE,  16'h0000, 4'd13, 1, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_DEQUEUE, 16'h0000, 4'd0, 13, 0, 0, 16'h0000, 0, 5'd0,  0);
        row(CMD_DEQUEUE, 16'h0000, 4'd0,  1, 1, 0, 16'h0000, 0, 5'd0,  1);
        row(CMD_SEARCH,  16'hA001, 4'd0,  1, 1, 1, 16'h0000, 0, 5'd0,  1);

        foreach (dir_rows[i])
        begin
            for (int k = 0; k < dir_rows[i].reps; k++)
            begin
                w.command     = dir_rows[i].cmd;
                w.task_handle = dir_rows[i].handle + 16'(k);
                w.position    = dir_rows[i].pos;
                send_word(w, dir_rows[i].pinned, dir_rows[i].rsp, pick_gap(1'b0));
            end
        end

        // Sender pause: everything owed must come back before random traffic.
        drain_owed();

        // Random traffic in blocks of 64 words. Each block leans toward
        // filling, draining or neither so the count sweeps empty..full; some
        // blocks run with no idle gaps at all.
        mode = 0;
        calm = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 64 == 0)
            begin
                mode = $urandom_range(2);
                calm = ($urandom_range(3) == 0);
            end
            if (n > 0 && n % 256 == 0)
                drain_owed();

            r = $urandom_range(99);
            case (mode)
                0:       w.command = (r < 55) ? CMD_ENQUEUE : (r < 65) ? CMD_DEQUEUE :
                                     (r < 85) ? CMD_SEARCH  : CMD_REMOVE;
                1:       w.command = (r < 10) ? CMD_ENQUEUE : (r < 45) ? CMD_DEQUEUE :
                                     (r < 65) ? CMD_SEARCH  : CMD_REMOVE;
                default: w.command = (r < 30) ? CMD_ENQUEUE : (r < 50) ? CMD_DEQUEUE :
                                     (r < 75) ? CMD_SEARCH  : CMD_REMOVE;
            endcase

            // Handles: a small pool for duplicates, live entries for search
            // hits, otherwise anything.
            r = $urandom_range(9);
            if (r < 4)
                w.task_handle = pool[$urandom_range(7)];
            else if (r < 6 && slot_q.size() > 0)
                w.task_handle = slot_q[$urandom_range(slot_q.size() - 1)];
            else
                w.task_handle = 16'($urandom);

            // Positions: mostly a valid index, else any index.
            if (slot_q.size() > 0 && $urandom_range(9) < 7)
                w.position = 4'($urandom_range(slot_q.size() - 1));
            else
                w.position = 4'($urandom_range(15));

            send_word(w, 1'b0, '0, pick_gap(calm));
        end

        // Wind down: wait for every owed word, then a quiet tail in which
        // any further done is flagged by the monitor.
        drain_owed();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (owed_q.size() > 0)
        begin
            mismatches += owed_q.size();
            $display("%0d result words never arrived", owed_q.size());
        end

        $display("%0d words: enqueue %0d, dequeue %0d, search %0d, remove %0d",
                 sent_words, cmd_seen[CMD_ENQUEUE], cmd_seen[CMD_DEQUEUE],
                 cmd_seen[CMD_SEARCH], cmd_seen[CMD_REMOVE]);
        $display("refused %0d (full %0d), search hits %0d, peak fill %0d, mismatches %0d",
                 refused, full_hits, search_hits, max_fill, mismatches);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
